>>> hdl/nau_pkg.sv
// ----------------------------------------------------------------------------
// nau_pkg
// Shared constants, types and the tanh breakpoint table builder for the
// neural activation unit.
// ----------------------------------------------------------------------------
package nau_pkg;

  localparam int unsigned TABLE_ADDR_BITS = 8;
  localparam int unsigned FRACTION_BITS   = 8;

  localparam int unsigned DATA_W    = 16;
  localparam int unsigned MAG_W     = DATA_W + 1;
  localparam int unsigned SEG_COUNT = 1 << TABLE_ADDR_BITS;
  localparam int unsigned ADDR_W    = TABLE_ADDR_BITS + 1;
  localparam int unsigned ROM_W     = 31;
  localparam int unsigned FRAC_W    = FRACTION_BITS + 4;
  localparam int unsigned PROD_W    = ROM_W + FRAC_W;
  localparam int unsigned P_W       = MAG_W + TABLE_ADDR_BITS;
  localparam int unsigned ACC_W     = 32;

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  typedef enum logic [1:0] {
    MODE_SIGMOID = 2'd0,
    MODE_TANH    = 2'd1,
    MODE_RELU    = 2'd2,
    MODE_UNSUP   = 2'd3
  } act_mode_e;

  typedef logic [ROM_W-1:0] rom_t [SEG_COUNT+1];

  // tanh(8*i/SEG_COUNT) in unsigned Q30; elaboration time only
  function automatic logic [ROM_W-1:0] tanh_entry(int unsigned i);
    logic [63:0] z;
    logic [63:0] w;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quo;
    logic [63:0] rem;
    z    = 64'(i) << (34 - TABLE_ADDR_BITS);
    w    = z >> 8;
    term = Q30_ONE;
    sum  = Q30_ONE;
    term = ((term * w) >> 30) / 64'd1;
    sum  = sum - term;
    term = ((term * w) >> 30) / 64'd2;
    sum  = sum + term;
    term = ((term * w) >> 30) / 64'd3;
    sum  = sum - term;
    term = ((term * w) >> 30) / 64'd4;
    sum  = sum + term;
    term = ((term * w) >> 30) / 64'd5;
    sum  = sum - term;
    term = ((term * w) >> 30) / 64'd6;
    sum  = sum + term;
    for (int k = 0; k < 8; k++) begin
      sum = (sum * sum) >> 30;
    end
    if (sum > Q30_ONE) begin
      sum = Q30_ONE;
    end
    num = (Q30_ONE - sum) << 30;
    den = Q30_ONE + sum;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo[ROM_W-1:0];
  endfunction

  function automatic rom_t build_tanh_rom();
    rom_t rom;
    for (int unsigned i = 0; i <= SEG_COUNT; i++) begin
      rom[i] = tanh_entry(i);
    end
    return rom;
  endfunction

endpackage

>>> hdl/neural_activation_unit_top.sv
// ----------------------------------------------------------------------------
// neural_activation_unit_top
// Element-wise sigmoid / tanh / ReLU activation of signed Q8.8 pixels.
// ----------------------------------------------------------------------------
// Takes one pixel beat per clock while in_stall_o is low and returns one
// result beat per pixel, in order, through the stage 1, stage 2 and output
// registers. The pipeline is: two-port read of the 257-entry tanh
// breakpoint table, the interpolation multiply, then sum, rounding and
// saturation into the output register. Input stall rises only when every
// stage holds a beat and the output is stalled. Write the mode (reset:
// ReLU) only while no beat is in flight; mode 3 returns zero with
// mode_error_o set.
module neural_activation_unit_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [nau_pkg::DATA_W-1:0]  in_value_i,
  input  logic                        is_last_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [nau_pkg::DATA_W-1:0]  out_value_o,
  output logic                        out_last_o,
  output logic                        mode_error_o
);
  import nau_pkg::*;

  localparam rom_t TanhRom = build_tanh_rom();
  localparam int unsigned FB = FRACTION_BITS;
  localparam logic signed [MAG_W:0] OutMax = (MAG_W+1)'((1 << (DATA_W - 1)) - 1);
  localparam logic signed [MAG_W:0] OutMin = -OutMax - (MAG_W+1)'(1);
  localparam logic [ACC_W-1:0] Half     = ACC_W'(1) << 29;
  localparam logic [ACC_W-1:0] RndHalf  = ACC_W'(1) << (29 - FB);

  act_mode_e act_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_mode_q <= MODE_RELU;
    end else if (cfg_we_i) begin
      act_mode_q <= act_mode_e'(cfg_wdata_i);
    end
  end

  // handshake
  logic v1_q, v2_q;
  logic rdy1, rdy2, rdy3;

  assign rdy3       = !out_valid_o || !out_stall_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_stall_o = !rdy1;

  // stage 0: table address and fraction
  logic                     neg0;
  logic signed [MAG_W-1:0]  vext0;
  logic [MAG_W-1:0]         mag0;
  logic [P_W-1:0]           p0;
  logic [P_W-1:0]           idx0;
  logic [FRAC_W-1:0]        frac0;
  logic                     sat0;
  logic [ADDR_W-1:0]        addr_lo0, addr_hi0;

  always_comb begin
    neg0  = in_value_i[DATA_W-1];
    vext0 = {in_value_i[DATA_W-1], in_value_i};
    mag0  = neg0 ? MAG_W'(-vext0) : MAG_W'(vext0);
    p0    = {mag0, {TABLE_ADDR_BITS{1'b0}}};
    if (act_mode_q == MODE_SIGMOID) begin
      idx0  = p0 >> (FB + 4);
      frac0 = p0[FRAC_W-1:0];
    end else begin
      idx0  = p0 >> (FB + 3);
      frac0 = {p0[FRAC_W-2:0], 1'b0};
    end
    sat0 = idx0 >= P_W'(SEG_COUNT);
    if (sat0) begin
      addr_lo0 = ADDR_W'(SEG_COUNT);
      addr_hi0 = ADDR_W'(SEG_COUNT);
      frac0    = '0;
    end else begin
      addr_lo0 = idx0[ADDR_W-1:0];
      addr_hi0 = idx0[ADDR_W-1:0] + ADDR_W'(1);
    end
  end

  // stage 1: table read
  logic [ROM_W-1:0]   lo1_q, hi1_q;
  logic [FRAC_W-1:0]  frac1_q;
  logic               neg1_q, last1_q;
  logic [DATA_W-1:0]  val1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      lo1_q   <= TanhRom[addr_lo0];
      hi1_q   <= TanhRom[addr_hi0];
      frac1_q <= frac0;
      neg1_q  <= neg0;
      val1_q  <= in_value_i;
      last1_q <= is_last_i;
    end
  end

  // stage 2: interpolation product
  logic [ROM_W-1:0]   diff1;
  logic [ROM_W-1:0]   lo2_q;
  logic [PROD_W-1:0]  prod2_q;
  logic               neg2_q, last2_q;
  logic [DATA_W-1:0]  val2_q;

  assign diff1 = (hi1_q >= lo1_q) ? hi1_q - lo1_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      lo2_q   <= lo1_q;
      prod2_q <= PROD_W'(diff1) * PROD_W'(frac1_q);
      neg2_q  <= neg1_q;
      val2_q  <= val1_q;
      last2_q <= last1_q;
    end
  end

  // stage 3: activation, rounding, saturation
  logic [ACC_W-1:0]         t2, y2, rnd2;
  logic [MAG_W-1:0]         mag2;
  logic signed [MAG_W:0]    res2;
  logic [DATA_W-1:0]        out_d;
  logic                     err_d;

  always_comb begin
    t2   = ACC_W'(lo2_q) + ACC_W'(prod2_q >> FRAC_W);
    y2   = t2;
    if (act_mode_q == MODE_SIGMOID) begin
      y2 = neg2_q ? Half - (t2 >> 1) : Half + (t2 >> 1);
    end
    rnd2  = (y2 + RndHalf) >> (30 - FB);
    mag2  = rnd2[MAG_W-1:0];
    err_d = 1'b0;
    unique case (act_mode_q)
      MODE_SIGMOID: res2 = $signed({1'b0, mag2});
      MODE_TANH:    res2 = neg2_q ? -$signed({1'b0, mag2}) : $signed({1'b0, mag2});
      MODE_RELU:    res2 = neg2_q ? '0 : (MAG_W+1)'($signed(val2_q));
      default: begin
        res2  = '0;
        err_d = 1'b1;
      end
    endcase
    if (res2 > OutMax) begin
      out_d = DATA_W'(OutMax);
    end else if (res2 < OutMin) begin
      out_d = DATA_W'(OutMin);
    end else begin
      out_d = DATA_W'(res2);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (rdy3) begin
      out_valid_o <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      out_value_o  <= out_d;
      out_last_o   <= last2_q;
      mode_error_o <= err_d;
    end
  end

`ifndef ASSERT_OFF
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_error_o |-> out_value_o == '0)
    else $error("mode error beat with nonzero value");

  a_relu_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && act_mode_q == MODE_RELU |-> !out_value_o[DATA_W-1])
    else $error("negative relu result");

  a_sig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && act_mode_q == MODE_SIGMOID
      |-> !out_value_o[DATA_W-1] && out_value_o <= DATA_W'(1 << FB))
    else $error("sigmoid result out of range");

  a_tanh_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && act_mode_q == MODE_TANH
      |-> $signed(out_value_o) <= $signed(DATA_W'(1 << FB))
       && $signed(out_value_o) >= -$signed(DATA_W'(1 << FB)))
    else $error("tanh result out of range");

  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output register");
`endif

endmodule

>>> tb/neural_activation_unit_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// neural_activation_unit_top_tb
// Self-checking bench for the sigmoid / tanh / ReLU activation unit.
// ----------------------------------------------------------------------------
// A directed table covers reset mode, field extremes, the table edge, the most
// negative pixel and the unsupported mode. Random pixels follow in segments,
// one mode per segment, rewritten while the unit is drained. Typed rows carry
// their expected beat, others go to a fixed-point activation model built from
// its own tanh table. Both handshakes idle at random in two of three phases.
// ----------------------------------------------------------------------------
module neural_activation_unit_top_tb;
  import nau_pkg::*;

  typedef bit [63:0] u64_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              last;
    logic              err;
  } act_beat_t;

  typedef struct packed {
    act_mode_e         mode;
    logic [DATA_W-1:0] px;
    logic              last;
    logic              typed;
    logic [DATA_W-1:0] want;
    logic              want_err;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 24;
  localparam int SEGMENTS      = 8;
  localparam int SEG_PIXELS    = 100;

  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{MODE_RELU,    16'h7FFF, 1'b0, 1'b1, 16'h7FFF, 1'b0},
    '{MODE_RELU,    16'h8000, 1'b1, 1'b1, 16'h0000, 1'b0},
    '{MODE_RELU,    16'h0180, 1'b0, 1'b1, 16'h0180, 1'b0},
    '{MODE_RELU,    16'hFFFF, 1'b0, 1'b1, 16'h0000, 1'b0},
    '{MODE_RELU,    16'h0000, 1'b0, 1'b1, 16'h0000, 1'b0},
    '{MODE_TANH,    16'h0000, 1'b0, 1'b1, 16'h0000, 1'b0},
    '{MODE_TANH,    16'h7FFF, 1'b0, 1'b1, 16'h0100, 1'b0},
    '{MODE_TANH,    16'h8000, 1'b0, 1'b1, 16'hFF00, 1'b0},
    '{MODE_TANH,    16'h0100, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{MODE_TANH,    16'hFF00, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{MODE_TANH,    16'h0008, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{MODE_TANH,    16'h07FF, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{MODE_TANH,    16'h0800, 1'b1, 1'b1, 16'h0100, 1'b0},
    '{MODE_SIGMOID, 16'h0000, 1'b0, 1'b1, 16'h0080, 1'b0},
    '{MODE_SIGMOID, 16'h7FFF, 1'b0, 1'b1, 16'h0100, 1'b0},
    '{MODE_SIGMOID, 16'h8000, 1'b0, 1'b1, 16'h0000, 1'b0},
    '{MODE_SIGMOID, 16'h0100, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{MODE_SIGMOID, 16'hFE00, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{MODE_SIGMOID, 16'h1000, 1'b0, 1'b1, 16'h0100, 1'b0},
    '{MODE_SIGMOID, 16'h0FFF, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{MODE_UNSUP,   16'h1234, 1'b1, 1'b1, 16'h0000, 1'b1},
    '{MODE_UNSUP,   16'h8000, 1'b0, 1'b1, 16'h0000, 1'b1},
    '{MODE_UNSUP,   16'h7FFF, 1'b1, 1'b1, 16'h0000, 1'b1},
    '{MODE_RELU,    16'h0001, 1'b0, 1'b1, 16'h0001, 1'b0}
  };

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              cfg_we_i     = 1'b0;
  logic [1:0]        cfg_wdata_i  = 2'd0;
  logic              in_valid_i   = 1'b0;
  logic              in_stall_o;
  logic [DATA_W-1:0] in_value_i   = '0;
  logic              is_last_i    = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i  = 1'b0;
  logic [DATA_W-1:0] out_value_o;
  logic              out_last_o;
  logic              mode_error_o;

  u64_t      tanh_bp [SEG_COUNT+1];
  act_beat_t pending_q [$];
  act_mode_e cur_mode;
  int        src_idle_pct   = 16;
  int        sink_stall_pct = 50;
  int        mismatches     = 0;

  neural_activation_unit_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_value_i  (in_value_i),
    .is_last_i   (is_last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_value_o (out_value_o),
    .out_last_o  (out_last_o),
    .mode_error_o(mode_error_o)
  );

  always #4 clk_i = ~clk_i;

  // exp(-z) in Q30: truncated series on z/256, then squared eight times
  function automatic u64_t exp_neg(u64_t z);
    u64_t w;
    u64_t term;
    u64_t acc;
    w    = z >> 8;
    term = Q30_ONE;
    acc  = Q30_ONE;
    for (int k = 1; k <= 6; k++) begin
      term = ((term * w) >> 30) / u64_t'(k);
      if (k % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    repeat (8) acc = (acc * acc) >> 30;
    return acc;
  endfunction

  function automatic u64_t tanh_point(int unsigned i);
    u64_t e;
    e = exp_neg(u64_t'(i) << (34 - TABLE_ADDR_BITS));
    if (e > Q30_ONE) begin
      e = Q30_ONE;
    end
    return ((Q30_ONE - e) << 30) / (Q30_ONE + e);
  endfunction

  function automatic u64_t interp_tanh(int unsigned mag, int unsigned sh);
    u64_t p;
    u64_t seg;
    u64_t frac;
    u64_t lo;
    u64_t hi;
    u64_t d;
    p   = u64_t'(mag) << TABLE_ADDR_BITS;
    seg = p >> sh;
    if (seg >= SEG_COUNT) begin
      return tanh_bp[SEG_COUNT];
    end
    frac = p & ((u64_t'(1) << sh) - 1);
    lo   = tanh_bp[seg];
    hi   = tanh_bp[seg + 1];
    d    = (hi >= lo) ? hi - lo : 0;
    return lo + ((d * frac) >> sh);
  endfunction

  function automatic int round_q30(u64_t y);
    return int'((y + (u64_t'(1) << (29 - FRACTION_BITS))) >> (30 - FRACTION_BITS));
  endfunction

  function automatic act_beat_t activate(act_mode_e mode, logic [DATA_W-1:0] px,
                                         logic last);
    act_beat_t   res;
    int          v;
    int unsigned mag;
    bit          neg;
    int          r;
    u64_t        t;
    v       = $signed(px);
    neg     = v < 0;
    mag     = neg ? -v : v;
    res.err = 1'b0;
    case (mode)
      MODE_SIGMOID: begin
        t = interp_tanh(mag, FRACTION_BITS + 4);
        r = round_q30(neg ? Q30_ONE / 2 - t / 2 : Q30_ONE / 2 + t / 2);
      end
      MODE_TANH: begin
        r = round_q30(interp_tanh(mag, FRACTION_BITS + 3));
        if (neg) begin
          r = -r;
        end
      end
      MODE_RELU: r = neg ? 0 : v;
      default: begin
        r       = 0;
        res.err = 1'b1;
      end
    endcase
    if (r > 32767) begin
      r = 32767;
    end
    if (r < -32768) begin
      r = -32768;
    end
    res.value = r[DATA_W-1:0];
    res.last  = last;
    return res;
  endfunction

  function automatic logic [DATA_W-1:0] rand_pixel();
    int unsigned m;
    case ($urandom_range(0, 7))
      0, 1, 2: return DATA_W'($urandom);
      3: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      4, 5: m = $urandom_range(0, 700);
      default: m = $urandom_range(0, 4200);
    endcase
    return $urandom_range(0, 1) ? DATA_W'(-int'(m)) : DATA_W'(m);
  endfunction

  function automatic void flag_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) begin
      $display("MISMATCH at %0t: %s", $realtime, what);
    end
  endfunction

  task automatic send_pixel(input logic [DATA_W-1:0] px, input logic last,
                            input act_beat_t want);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_value_i <= px;
    is_last_i  <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_q.push_back(want);
  endtask

  task automatic drain_unit();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_mode(input act_mode_e m);
    drain_unit();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_mode     = m;
  endtask

  // output side: random stall, compare each beat with the oldest prediction
  always @(posedge clk_i) begin
    act_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat value=%h last=%b err=%b",
                                out_value_o, out_last_o, mode_error_o));
      end else begin
        want = pending_q.pop_front();
        if (out_value_o !== want.value || out_last_o !== want.last ||
            mode_error_o !== want.err) begin
          flag_mismatch($sformatf("exp value=%h last=%b err=%b, got value=%h last=%b err=%b",
                                  want.value, want.last, want.err,
                                  out_value_o, out_last_o, mode_error_o));
        end
      end
    end
    out_stall_i <= ($urandom_range(0, 99) < sink_stall_pct);
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    act_mode_e         seg_mode;
    act_beat_t         want;
    logic [DATA_W-1:0] px;
    logic              last;
    for (int i = 0; i <= SEG_COUNT; i++) begin
      tanh_bp[i] = tanh_point(i);
    end
    cur_mode = MODE_RELU;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (DIRECTED[r].mode != cur_mode) begin
        set_mode(DIRECTED[r].mode);
      end
      if (DIRECTED[r].typed) begin
        want = '{DIRECTED[r].want, DIRECTED[r].last, DIRECTED[r].want_err};
      end else begin
        want = activate(cur_mode, DIRECTED[r].px, DIRECTED[r].last);
      end
      send_pixel(DIRECTED[r].px, DIRECTED[r].last, want);
    end

    for (int s = 0; s < SEGMENTS; s++) begin
      case (s)
        0: seg_mode = MODE_SIGMOID;
        1: seg_mode = MODE_TANH;
        2: seg_mode = MODE_RELU;
        3: seg_mode = MODE_UNSUP;
        4: seg_mode = MODE_TANH;
        5: seg_mode = MODE_SIGMOID;
        6: seg_mode = MODE_RELU;
        default: seg_mode = act_mode_e'($urandom_range(0, 3));
      endcase
      set_mode(seg_mode);
      if (s < 3) begin
        src_idle_pct   = 16;
        sink_stall_pct = 50;
      end else if (s < 6) begin
        src_idle_pct   = 50;
        sink_stall_pct = 16;
      end else begin
        src_idle_pct   = 0;
        sink_stall_pct = 0;
      end
      for (int n = 0; n < SEG_PIXELS; n++) begin
        px   = rand_pixel();
        last = (n == SEG_PIXELS - 1) || ($urandom_range(0, 15) == 0);
        send_pixel(px, last, activate(cur_mode, px, last));
      end
    end

    drain_unit();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/nau_pkg.sv
hdl/neural_activation_unit_top.sv
tb/neural_activation_unit_top_tb.sv
